/* src/ssig_pkg.sv */
// Shared types, constants and helpers for the strided slice index generator.
// No dependencies; every other file imports this package.
`default_nettype none

package ssig_pkg;

  localparam int unsigned IDX_W  = 32;
  localparam int unsigned LANE_W = 16;
  localparam int unsigned LANES  = 4;
  localparam int unsigned CFG_W  = 64;
  localparam int unsigned ADDR_W = 6;
  localparam int unsigned RANK_W = 3;

  localparam logic [CFG_W-1:0] LANE_ONES = 64'h0001_0001_0001_0001;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LANE_W-1:0] lane_t;
  typedef logic [CFG_W-1:0]  cfg_word_t;

  typedef enum logic [2:0] {
    REG_RANK       = 3'd0,
    REG_BEGIN      = 3'd1,
    REG_STEP       = 3'd2,
    REG_IN_STRIDE  = 3'd3,
    REG_OUT_STRIDE = 3'd4
  } cfg_reg_t;

  // 16-bit lane d of a packed configuration word, dimension 0 in the low bits
  function automatic lane_t lane_of(input cfg_word_t pv, input int unsigned d);
    return pv[(d % LANES)*LANE_W +: LANE_W];
  endfunction

endpackage

`default_nettype wire

/* src/ssig_div_cell.sv */
// One restoring-division step cell of the coordinate divider chain.
// Depends on ssig_pkg.
`default_nettype none

module ssig_div_cell
  import ssig_pkg::*;
#(
  parameter int unsigned QW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire idx_t          in_x,
  input  wire idx_t          in_p,
  input  wire logic [QW-1:0] in_q,
  input  wire lane_t         divisor,
  output logic               out_valid,
  output idx_t               out_x,
  output idx_t               out_p,
  output logic [QW-1:0]      out_q
);

  logic          valid_r;
  idx_t          x_r;
  idx_t          p_r;
  logic [QW-1:0] q_r;

  idx_t p_sh;
  logic take;
  idx_t x_nxt;
  idx_t p_nxt;

  // A zero divisor never subtracts: quotient comes out 0 and the partial
  // remainder collects the whole dividend, so the value passes on untouched.
  always_comb begin
    p_sh  = {in_p[IDX_W-2:0], in_x[IDX_W-1]};
    take  = (divisor != '0) && (p_sh >= IDX_W'(divisor));
    x_nxt = {in_x[IDX_W-2:0], take};
    p_nxt = take ? (p_sh - IDX_W'(divisor)) : p_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      p_r <= p_nxt;
      q_r <= in_q;
    end
  end

  assign out_valid = valid_r;
  assign out_x     = x_r;
  assign out_p     = p_r;
  assign out_q     = q_r;

endmodule

`default_nettype wire

/* src/ssig_combine.sv */
// Back end: scales each coordinate by its step, adds the start, weights by the
// input stride and sums the lanes into the source index. Depends on ssig_pkg.
`default_nettype none

module ssig_combine
  import ssig_pkg::*;
#(
  parameter int unsigned NLANE = 4
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic [NLANE*IDX_W-1:0]  coord,
  input  wire cfg_word_t               start_v,
  input  wire cfg_word_t               step_v,
  input  wire logic [NLANE*LANE_W-1:0] weight,
  output logic                         out_valid,
  output idx_t                         out_src
);

  logic v1_r;
  logic v2_r;
  logic v3_r;
  idx_t loc_r  [NLANE];
  idx_t prod_r [NLANE];
  idx_t src_r;

  idx_t loc_nxt  [NLANE];
  idx_t prod_nxt [NLANE];
  idx_t src_nxt;

  for (genvar d = 0; d < NLANE; d++) begin : g_lane
    lane_t s;
    idx_t  s_ext;
    assign s     = lane_of(step_v, d);
    assign s_ext = {{(IDX_W-LANE_W){s[LANE_W-1]}}, s};
    assign loc_nxt[d]  = idx_t'(coord[d*IDX_W +: IDX_W] * s_ext)
                       + IDX_W'(lane_of(start_v, d));
    assign prod_nxt[d] = idx_t'(loc_r[d] * IDX_W'(weight[d*LANE_W +: LANE_W]));
  end

  always_comb begin
    src_nxt = '0;
    for (int d = 0; d < NLANE; d++) begin
      src_nxt = src_nxt + prod_r[d];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      loc_r  <= loc_nxt;
      prod_r <= prod_nxt;
      src_r  <= src_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_src   = src_r;

endmodule

`default_nettype wire

/* src/strided_slice_index_generator_core.sv */
// Top level of the strided slice index generator: config registers, divider
// cell chain and combine back end. Depends on ssig_pkg, ssig_div_cell, ssig_combine.
`default_nettype none

// Maps each flat output index to the flat source index of a strided slice.
// One transaction is accepted per cycle while the pipeline is not stalled. The
// divider chain comes first, where one cell produces one quotient bit for one
// outer dimension, followed by the step, stride and sum stages. The whole
// pipeline advances when the output register is empty or being taken.
// Registers sit at byte address 8*i; the user must write them only while no
// transaction is in flight, as the block itself does not enforce this.
module strided_slice_index_generator_core
  import ssig_pkg::*;
#(
  parameter int unsigned MAX_RANK = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire cfg_word_t         pwdata,
  output cfg_word_t              prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire idx_t              in_out_index,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output idx_t                   out_src_index
);

  localparam int unsigned NQ    = (MAX_RANK > 1) ? MAX_RANK - 1 : 1;
  localparam int unsigned NSTEP = (MAX_RANK - 1) * IDX_W;

  logic [RANK_W-1:0] rank_r;
  cfg_word_t         begin_r;
  cfg_word_t         step_r;
  cfg_word_t         in_stride_r;
  cfg_word_t         out_stride_r;

  logic              cfg_wr;
  cfg_reg_t          cfg_sel;
  logic [RANK_W-1:0] rank_eff;
  logic              chain_en;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_t'(paddr[ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r       <= RANK_W'(1);
      begin_r      <= '0;
      step_r       <= LANE_ONES;
      in_stride_r  <= LANE_ONES;
      out_stride_r <= LANE_ONES;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_RANK:       rank_r       <= pwdata[RANK_W-1:0];
        REG_BEGIN:      begin_r      <= pwdata;
        REG_STEP:       step_r       <= pwdata;
        REG_IN_STRIDE:  in_stride_r  <= pwdata;
        REG_OUT_STRIDE: out_stride_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_RANK:       prdata = CFG_W'(rank_r);
      REG_BEGIN:      prdata = begin_r;
      REG_STEP:       prdata = step_r;
      REG_IN_STRIDE:  prdata = in_stride_r;
      REG_OUT_STRIDE: prdata = out_stride_r;
      default:        prdata = '0;
    endcase
  end

  // rank 0 behaves as 1, anything above MAX_RANK saturates
  always_comb begin
    if (rank_r == '0) begin
      rank_eff = RANK_W'(1);
    end else if (rank_r > RANK_W'(MAX_RANK)) begin
      rank_eff = RANK_W'(MAX_RANK);
    end else begin
      rank_eff = rank_r;
    end
  end

  assign chain_en = !out_valid || out_ready;
  assign in_ready = chain_en && rst_n;

  // ---------------- divider chain ----------------
  logic                  st_v [0:NSTEP];
  idx_t                  st_x [0:NSTEP];
  idx_t                  st_p [0:NSTEP];
  logic [NQ*IDX_W-1:0]   st_q [0:NSTEP];
  lane_t                 div_g [NQ];

  assign st_v[0] = in_valid;
  assign st_x[0] = in_out_index;
  assign st_p[0] = '0;
  assign st_q[0] = '0;

  // dimensions at or past rank-1 get a zero divisor and so pass straight through
  for (genvar g = 0; g < NQ; g++) begin : g_div
    assign div_g[g] = (RANK_W'(g + 1) < rank_eff) ? lane_of(out_stride_r, g) : '0;
  end

  for (genvar k = 0; k < NSTEP; k++) begin : g_cell
    localparam int unsigned G = k / IDX_W;
    idx_t                c_x;
    idx_t                c_p;
    logic [NQ*IDX_W-1:0] c_q;

    if ((k % IDX_W == 0) && (k > 0)) begin : g_bound
      // new dimension: remainder becomes the dividend, quotient is parked
      assign c_x = st_p[k];
      assign c_p = '0;
      always_comb begin
        c_q = st_q[k];
        c_q[(G-1)*IDX_W +: IDX_W] = st_x[k];
      end
    end else begin : g_thru
      assign c_x = st_x[k];
      assign c_p = st_p[k];
      assign c_q = st_q[k];
    end

    ssig_div_cell #(
      .QW (NQ*IDX_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (chain_en),
      .in_valid  (st_v[k]),
      .in_x      (c_x),
      .in_p      (c_p),
      .in_q      (c_q),
      .divisor   (div_g[G]),
      .out_valid (st_v[k+1]),
      .out_x     (st_x[k+1]),
      .out_p     (st_p[k+1]),
      .out_q     (st_q[k+1])
    );
  end

  logic [NQ*IDX_W-1:0] q_fin;
  idx_t                rem;

  if (MAX_RANK > 1) begin : g_qfin
    always_comb begin
      q_fin = st_q[NSTEP];
      q_fin[(NQ-1)*IDX_W +: IDX_W] = st_x[NSTEP];
    end
  end else begin : g_qnone
    assign q_fin = st_q[NSTEP];
  end
  assign rem = st_p[NSTEP] | st_x[NSTEP] & {IDX_W{MAX_RANK == 1}};

  // ---------------- coordinates and weights ----------------
  logic [MAX_RANK*IDX_W-1:0]  coord_v;
  logic [MAX_RANK*LANE_W-1:0] weight_v;

  for (genvar d = 0; d < MAX_RANK; d++) begin : g_coord
    if (d < MAX_RANK - 1) begin : g_outer
      assign coord_v[d*IDX_W +: IDX_W] =
          (RANK_W'(d + 1) < rank_eff)  ? q_fin[d*IDX_W +: IDX_W] :
          (RANK_W'(d + 1) == rank_eff) ? rem : '0;
    end else begin : g_last
      assign coord_v[d*IDX_W +: IDX_W] = (RANK_W'(d + 1) == rank_eff) ? rem : '0;
    end
    assign weight_v[d*LANE_W +: LANE_W] =
        (RANK_W'(d + 1) < rank_eff)  ? lane_of(in_stride_r, d) :
        (RANK_W'(d + 1) == rank_eff) ? LANE_W'(1) : '0;
  end

  ssig_combine #(
    .NLANE (MAX_RANK)
  ) u_combine (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (chain_en),
    .in_valid  (st_v[NSTEP]),
    .coord     (coord_v),
    .start_v   (begin_r),
    .step_v    (step_r),
    .weight    (weight_v),
    .out_valid (out_valid),
    .out_src   (out_src_index)
  );

`ifndef NO_ASSERTIONS
  if (MAX_RANK > 1) begin : g_chk
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
      (st_v[IDX_W] && (div_g[0] != '0)) |-> (st_p[IDX_W] < IDX_W'(div_g[0])))
      else $error("divider remainder not below divisor");

    a_zero_divisor_quotient: assert property (@(posedge clk) disable iff (!rst_n)
      (st_v[IDX_W] && (div_g[0] == '0)) |-> (st_x[IDX_W] == '0))
      else $error("zero output stride gave a non-zero coordinate");

    a_chain_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
      (!chain_en && st_v[NSTEP]) |=> (st_v[NSTEP] && $stable(st_x[NSTEP])
                                      && $stable(st_p[NSTEP])))
      else $error("divider chain moved while stalled");
  end
`endif

endmodule

`default_nettype wire
